>>> src/mmtbp_pkg.sv
package mmtbp_pkg;

  localparam int GHIST_MAX_DEF    = 13;
  localparam int LHIST_MAX_DEF    = 12;
  localparam int PC_INDEX_MAX_DEF = 12;

  localparam logic [1:0] MODE_STATIC = 2'd0;
  localparam logic [1:0] MODE_GSHARE = 2'd1;
  localparam logic [1:0] MODE_LOCAL  = 2'd2;
  localparam logic [1:0] MODE_TOURN  = 2'd3;

  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_GHLEN = 2'd1;
  localparam logic [1:0] REG_LHLEN = 2'd2;
  localparam logic [1:0] REG_PCLEN = 2'd3;

  localparam logic [1:0] CTR_MAX = 2'h3;

  typedef struct packed {
    logic clr_step;   // write one clear row, advance sweep
    logic cap;        // capture request
    logic rd1;        // first table reads (local history, gshare counter)
    logic rd2;        // counter/chooser reads
    logic fin;        // predict out or train writeback
  } mmtbp_cmd_t;

  typedef struct packed {
    logic clr_done;
  } mmtbp_sts_t;

  function automatic logic [1:0] ctr_upd(input logic [1:0] c, input logic up);
    logic [1:0] r;
    r = c;
    if (up) begin
      if (c != CTR_MAX) r = c + 2'd1;
    end else begin
      if (c != 2'd0) r = c - 2'd1;
    end
    return r;
  endfunction

  // mask of the low len bits, len clamped to maxlen
  function automatic logic [31:0] low_mask(input logic [3:0] len, input int maxlen);
    int l;
    logic [32:0] m;
    l = (int'(len) > maxlen) ? maxlen : int'(len);
    m = (33'd1 << l) - 33'd1;
    return m[31:0];
  endfunction

endpackage

>>> src/mmtbp_ctrl.sv
module mmtbp_ctrl
  import mmtbp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  mmtbp_sts_t sts,
  output logic       busy,
  output mmtbp_cmd_t cmd
);

  typedef enum logic [2:0] {S_CLR, S_IDLE, S_RD1, S_RD2, S_FIN} state_t;
  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.cap = 1'b1;
          state_nxt = S_RD1;
        end
      end
      S_RD1: begin
        cmd.rd1 = 1'b1;
        state_nxt = S_RD2;
      end
      S_RD2: begin
        cmd.rd2 = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> src/mmtbp_dp.sv
module mmtbp_dp
  import mmtbp_pkg::*;
#(
  parameter int GHIST_MAX    = GHIST_MAX_DEF,
  parameter int LHIST_MAX    = LHIST_MAX_DEF,
  parameter int PC_INDEX_MAX = PC_INDEX_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  mmtbp_cmd_t  cmd,
  output mmtbp_sts_t  sts,
  input  logic [1:0]  mode,
  input  logic [3:0]  ghlen,
  input  logic [3:0]  lhlen,
  input  logic [3:0]  pclen,
  input  logic        in_cmd,
  input  logic [31:0] in_branch_address,
  input  logic        in_taken_outcome,
  output logic        out_valid,
  output logic        out_predict_taken
);

  localparam int GT = 1 << GHIST_MAX;
  localparam int LT = 1 << LHIST_MAX;
  localparam int PT = 1 << PC_INDEX_MAX;
  localparam int CW = (GHIST_MAX > PC_INDEX_MAX) ?
                      ((GHIST_MAX > LHIST_MAX) ? GHIST_MAX : LHIST_MAX) :
                      ((PC_INDEX_MAX > LHIST_MAX) ? PC_INDEX_MAX : LHIST_MAX);

  logic [1:0]           gctr_mem [GT];
  logic [1:0]           chs_mem  [GT];
  logic [LHIST_MAX-1:0] lhist_mem[PT];
  logic [1:0]           lctr_mem [LT];

  logic [CW:0]           clr_r;
  logic                  train_r, taken_r;
  logic [31:0]           pc_r;
  logic [GHIST_MAX-1:0]  ghist_r;
  logic [PC_INDEX_MAX-1:0] slot_r;
  logic [GHIST_MAX-1:0]  gsh_idx_r, gi_r;
  logic [LHIST_MAX-1:0]  lh_r;
  logic [1:0]            gsh_ctr_r, gctr_r, chs_r, lctr_r;
  logic                  out_valid_r, out_pred_r;

  logic [31:0] gmask, lmask, pmask;
  logic [LHIST_MAX-1:0] lidx;
  logic [CW-1:0] crow;

  assign gmask = low_mask(ghlen, GHIST_MAX);
  assign lmask = low_mask(lhlen, LHIST_MAX);
  assign pmask = low_mask(pclen, PC_INDEX_MAX);
  assign lidx  = lh_r & lmask[LHIST_MAX-1:0];
  assign crow  = clr_r[CW-1:0];
  assign sts.clr_done = clr_r[CW];

  // reset sweep over all tables, one row a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr_step && !clr_r[CW]) begin
      clr_r <= clr_r + 1'b1;
    end
  end

  logic gp, lp, upd_c, dir_c;
  logic [1:0] gnew;
  logic [GHIST_MAX-1:0] gwi;
  assign gp = gctr_r[1];
  assign lp = lctr_r[1];
  assign upd_c = (gp != taken_r) != (lp != taken_r);
  assign dir_c = (lp == taken_r);
  assign gwi  = (mode == MODE_GSHARE) ? gsh_idx_r : gi_r;
  assign gnew = ctr_upd((mode == MODE_GSHARE) ? gsh_ctr_r : gctr_r, taken_r);

  always_ff @(posedge clk) begin
    if (cmd.clr_step && !clr_r[CW]) begin
      if (clr_r < (CW+1)'(GT)) begin
        gctr_mem[crow[GHIST_MAX-1:0]] <= 2'd0;
        chs_mem[crow[GHIST_MAX-1:0]]  <= 2'd1;
      end
      if (clr_r < (CW+1)'(PT)) lhist_mem[crow[PC_INDEX_MAX-1:0]] <= '0;
      if (clr_r < (CW+1)'(LT)) lctr_mem[crow[LHIST_MAX-1:0]] <= 2'd0;
    end
    if (cmd.cap) begin
      train_r <= in_cmd;
      pc_r    <= in_branch_address;
      taken_r <= in_taken_outcome;
    end
    if (cmd.rd1) begin
      slot_r    <= pc_r[PC_INDEX_MAX-1:0] & pmask[PC_INDEX_MAX-1:0];
      lh_r      <= lhist_mem[pc_r[PC_INDEX_MAX-1:0] & pmask[PC_INDEX_MAX-1:0]];
      gsh_idx_r <= (pc_r[GHIST_MAX-1:0] ^ ghist_r) & gmask[GHIST_MAX-1:0];
      gi_r      <= ghist_r & gmask[GHIST_MAX-1:0];
      gsh_ctr_r <= gctr_mem[(pc_r[GHIST_MAX-1:0] ^ ghist_r) & gmask[GHIST_MAX-1:0]];
    end
    if (cmd.rd2) begin
      gctr_r <= gctr_mem[gi_r];
      chs_r  <= chs_mem[gi_r];
      lctr_r <= lctr_mem[lidx];
    end
    if (cmd.fin && train_r) begin
      if (mode == MODE_GSHARE || mode == MODE_TOURN) gctr_mem[gwi] <= gnew;
      if (mode == MODE_TOURN && upd_c) chs_mem[gi_r] <= ctr_upd(chs_r, dir_c);
      if (mode == MODE_LOCAL || mode == MODE_TOURN) begin
        lctr_mem[lidx]    <= ctr_upd(lctr_r, taken_r);
        lhist_mem[slot_r] <= {lh_r[LHIST_MAX-2:0], taken_r};
      end
    end
  end

  logic pred;
  always_comb begin
    unique case (mode)
      MODE_GSHARE: pred = gsh_ctr_r[1];
      MODE_LOCAL:  pred = lp;
      MODE_TOURN:  pred = chs_r[1] ? lp : gp;
      default:     pred = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ghist_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.fin && !train_r;
      if (cmd.fin && train_r && (mode == MODE_GSHARE || mode == MODE_TOURN))
        ghist_r <= {ghist_r[GHIST_MAX-2:0], taken_r};
    end
    out_pred_r <= pred;
  end

  assign out_valid         = out_valid_r;
  assign out_predict_taken = out_pred_r;

endmodule

>>> src/multi_mode_tournament_branch_predictor.sv
// Tournament branch predictor with static, gshare, local and tournament modes.
// Each command goes through the accept cycle, then local history and gshare
// counter read, counter reads, and prediction or table writeback; busy is
// high for all but the accept cycle. A predict raises out_valid for one cycle,
// the first cycle with busy low again; the receiver cannot stall it, so it must
// take out_predict_taken that cycle. Train produces no result. After reset the
// tables are cleared by a sweep over 2^max(GHIST_MAX, LHIST_MAX, PC_INDEX_MAX)
// rows (8192 by default) with busy high.
module multi_mode_tournament_branch_predictor
  import mmtbp_pkg::*;
#(
  parameter int GHIST_MAX    = GHIST_MAX_DEF,
  parameter int LHIST_MAX    = LHIST_MAX_DEF,
  parameter int PC_INDEX_MAX = PC_INDEX_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_cmd,
  input  logic [31:0] in_branch_address,
  input  logic        in_taken_outcome,
  output logic        out_valid,
  output logic        out_predict_taken,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [1:0] mode_r;
  logic [3:0] ghlen_r, lhlen_r, pclen_r;
  mmtbp_cmd_t cmd;
  mmtbp_sts_t sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_STATIC;
      ghlen_r <= 4'd13;
      lhlen_r <= 4'd10;
      pclen_r <= 4'd10;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_MODE:  mode_r  <= pwdata[1:0];
        REG_GHLEN: ghlen_r <= pwdata[3:0];
        REG_LHLEN: lhlen_r <= pwdata[3:0];
        REG_PCLEN: pclen_r <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MODE:  prdata = {30'd0, mode_r};
      REG_GHLEN: prdata = {28'd0, ghlen_r};
      REG_LHLEN: prdata = {28'd0, lhlen_r};
      REG_PCLEN: prdata = {28'd0, pclen_r};
      default:   prdata = '0;
    endcase
  end

  mmtbp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  mmtbp_dp #(
    .GHIST_MAX    (GHIST_MAX),
    .LHIST_MAX    (LHIST_MAX),
    .PC_INDEX_MAX (PC_INDEX_MAX)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .mode              (mode_r),
    .ghlen             (ghlen_r),
    .lhlen             (lhlen_r),
    .pclen             (pclen_r),
    .in_cmd            (in_cmd),
    .in_branch_address (in_branch_address),
    .in_taken_outcome  (in_taken_outcome),
    .out_valid         (out_valid),
    .out_predict_taken (out_predict_taken)
  );

endmodule

>>> sim/tb_multi_mode_tournament_branch_predictor.sv
`timescale 1ns / 1ps

module tb_multi_mode_tournament_branch_predictor;
  import mmtbp_pkg::*;

  localparam int GH_MAX = 13;
  localparam int LH_MAX = 12;
  localparam int PC_MAX = 12;
  localparam int WATCHDOG_LIMIT = 40000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_cmd;
  logic [31:0] in_branch_address;
  logic        in_taken_outcome;
  logic        out_valid;
  logic        out_predict_taken;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  multi_mode_tournament_branch_predictor uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_branch_address(in_branch_address),
    .in_taken_outcome(in_taken_outcome),
    .out_valid(out_valid), .out_predict_taken(out_predict_taken),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Mirror of the predictor tables; fills a queue of expected predictions.
  class prediction_board;
    logic [1:0]  mode;
    logic [3:0]  gh_len, lh_len, pc_len;
    logic [12:0] ghist;
    logic [1:0]  gctr[8192];
    logic [1:0]  chooser[8192];
    logic [11:0] lhist[4096];
    logic [1:0]  lctr[4096];
    bit          pending[$];
    int          errors;

    function new();
      mode = MODE_STATIC; gh_len = 4'd13; lh_len = 4'd10; pc_len = 4'd10;
      ghist = '0; errors = 0;
      foreach (gctr[i]) begin gctr[i] = 2'd0; chooser[i] = 2'd1; end
      foreach (lctr[i]) begin lctr[i] = 2'd0; lhist[i] = '0; end
    endfunction

    function logic [31:0] mask_of(logic [3:0] len, int maxlen);
      int l;
      l = (int'(len) > maxlen) ? maxlen : int'(len);
      return (l == 0) ? 32'd0 : ((32'd1 << l) - 32'd1);
    endfunction

    function logic [1:0] bump(logic [1:0] c, bit up);
      if (up) return (c == 2'd3) ? c : c + 2'd1;
      return (c == 2'd0) ? c : c - 2'd1;
    endfunction

    function int lidx(logic [31:0] pc);
      int slot;
      slot = pc & mask_of(pc_len, PC_MAX);
      return lhist[slot] & mask_of(lh_len, LH_MAX);
    endfunction

    function void note_item(bit cmd, logic [31:0] pc, bit taken);
      int gi, gs, li, slot;
      bit gp, lp;
      gi = ghist & mask_of(gh_len, GH_MAX);
      gs = (pc ^ ghist) & mask_of(gh_len, GH_MAX);
      li = lidx(pc);
      slot = pc & mask_of(pc_len, PC_MAX);
      gp = gctr[gi] > 1;
      lp = lctr[li] > 1;
      if (!cmd) begin
        case (mode)
          MODE_GSHARE: pending.push_back(gctr[gs] > 1);
          MODE_LOCAL:  pending.push_back(lp);
          MODE_TOURN:  pending.push_back((chooser[gi] > 1) ? lp : gp);
          default:     pending.push_back(1'b1);
        endcase
        return;
      end
      case (mode)
        MODE_GSHARE: begin
          gctr[gs] = bump(gctr[gs], taken);
          ghist = {ghist[11:0], taken};
        end
        MODE_LOCAL: begin
          lctr[li] = bump(lctr[li], taken);
          lhist[slot] = {lhist[slot][10:0], taken};
        end
        MODE_TOURN: begin
          if (gp != taken && lp == taken) chooser[gi] = bump(chooser[gi], 1'b1);
          else if (gp == taken && lp != taken) chooser[gi] = bump(chooser[gi], 1'b0);
          gctr[gi] = bump(gctr[gi], taken);
          ghist = {ghist[11:0], taken};
          lctr[li] = bump(lctr[li], taken);
          lhist[slot] = {lhist[slot][10:0], taken};
        end
        default: ;
      endcase
    endfunction

    function void check_prediction(bit got);
      bit want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected prediction, expected none, actual %0b", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (want !== got) begin
        $display("%0t: predict_taken mismatch, expected %0b, actual %0b", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  prediction_board board;
  int idle_pct;
  int quiet_cycles;
  int items_sent;

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) board.check_prediction(out_predict_taken);
    if ((start && !busy) || out_valid || (psel && penable)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [3:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= {28'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_MODE:  board.mode = value[1:0];
      REG_GHLEN: board.gh_len = value;
      REG_LHLEN: board.lh_len = value;
      default:   board.pc_len = value;
    endcase
    @(posedge clk);
  endtask

  // One transfer on the command channel, with random idle ahead of it.
  task automatic send_item(bit cmd, logic [31:0] pc, bit taken);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1; in_cmd <= cmd; in_branch_address <= pc; in_taken_outcome <= taken;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_item(cmd, pc, taken);
    items_sent++;
  endtask

  // Results trail busy; wait for busy low and the queue to drain, then idle on.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (busy || board.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_all(logic [1:0] m, logic [3:0] g, logic [3:0] l, logic [3:0] p);
    drain();
    write_reg(REG_MODE, {2'b00, m});
    write_reg(REG_GHLEN, g);
    write_reg(REG_LHLEN, l);
    write_reg(REG_PCLEN, p);
  endtask

  // Loop-like branches: a few PCs with repeating outcome patterns.
  task automatic random_run(int n);
    logic [31:0] pcs[4];
    logic [7:0]  pat[4];
    int k, ph;
    foreach (pcs[i]) begin pcs[i] = $urandom; pat[i] = $urandom; end
    ph = 0;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(3);
      if ($urandom_range(9) == 0) send_item($urandom_range(1), $urandom, $urandom_range(1));
      else begin
        send_item(1'b0, pcs[k], 1'b0);
        send_item(1'b1, pcs[k], pat[k][ph % 8]);
        ph++;
      end
    end
  endtask

  initial begin
    board = new();
    quiet_cycles = 0; items_sent = 0; idle_pct = 0;
    rst_n = 1'b0; start = 1'b0; in_cmd = 1'b0; in_branch_address = '0;
    in_taken_outcome = 1'b0; psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    paddr = '0; pwdata = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: defaults in static mode, then gshare, local and tournament with extreme lengths and addresses
    send_item(1'b0, 32'h0, 1'b0);
    send_item(1'b1, 32'hFFFF_FFFF, 1'b1);
    send_item(1'b0, 32'hFFFF_FFFF, 1'b1);
    set_all(MODE_GSHARE, 4'd15, 4'd15, 4'd15);
    for (int i = 0; i < 4; i++) send_item(1'b1, 32'hFFFF_FFFF, 1'b1);
    send_item(1'b0, 32'hFFFF_FFFF, 1'b0);
    send_item(1'b0, 32'h0, 1'b0);
    set_all(MODE_LOCAL, 4'd0, 4'd0, 4'd0);
    for (int i = 0; i < 3; i++) send_item(1'b1, 32'hA5A5_5A5A, 1'b1);
    send_item(1'b0, 32'h1234_5678, 1'b0);
    set_all(MODE_TOURN, 4'd1, 4'd12, 4'd12);
    for (int i = 0; i < 4; i++) send_item(1'b1, 32'h0000_0FFF, i[0]);
    send_item(1'b0, 32'h0000_0FFF, 1'b0);
    send_item(1'b0, 32'h8000_0000, 1'b0);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 48;
        2: idle_pct = 0;
        default: idle_pct = 11;
      endcase
      case (ph)
        0: set_all(MODE_TOURN, 4'd13, 4'd10, 4'd10);
        1: set_all(MODE_GSHARE, 4'd13, 4'd1, 4'd1);
        2: set_all(MODE_LOCAL, 4'd4, 4'd12, 4'd12);
        3: set_all(MODE_TOURN, 4'd3, 4'd2, 4'd3);
        4: set_all(MODE_STATIC, 4'd1, 4'd1, 4'd1);
        5: set_all(MODE_TOURN, 4'd15, 4'd15, 4'd15);
        6: set_all(MODE_GSHARE, 4'd6, 4'd7, 4'd8);
        default: set_all(MODE_LOCAL, 4'd13, 4'd5, 4'd2);
      endcase
      random_run(85);
    end

    drain();
    if (board.errors == 0 && board.pending.size() == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

>>> files.f
src/mmtbp_pkg.sv
src/mmtbp_ctrl.sv
src/mmtbp_dp.sv
src/multi_mode_tournament_branch_predictor.sv
sim/tb_multi_mode_tournament_branch_predictor.sv
